### src/tpcj_pkg.sv
// Shared types and constants for the track pair clone judge.
// Used by the judge logic, the top level and the port checker; no dependencies.
`default_nettype none

package tpcj_pkg;

  localparam int InDataW  = 144;
  localparam int OutDataW = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  localparam logic signed [25:0] ZLimit = 26'sd1013760;

  localparam logic [1:0] KindLong       = 2'd1;
  localparam logic [1:0] KindDownstream = 2'd2;
  localparam logic [1:0] KindT          = 2'd3;

  localparam logic [CfgIdxW-1:0] RegMatchFraction = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMatchLoose    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLooseEnable   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGateEnable    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegXWindow       = 3'd4;
  localparam logic [CfgIdxW-1:0] RegYWindow       = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTxWindow      = 3'd6;
  localparam logic [CfgIdxW-1:0] RegTyWindow      = 3'd7;

  typedef struct packed {
    logic [7:0]  hit_count;
    logic [1:0]  kind;
    logic        fitted;
    logic [17:0] chi2;
    logic        has_state;
    logic [25:0] z;
    logic [20:0] x;
    logic [20:0] y;
    logic [17:0] tx;
    logic [17:0] ty;
  } track_t;

  typedef struct packed {
    track_t     first;
    track_t     second;
    logic [7:0] shared_hits;
  } pair_t;

  typedef struct packed {
    logic [8:0]  match_fraction;
    logic [8:0]  match_fraction_loose;
    logic        loose_pair_enable;
    logic        closeness_gate_enable;
    logic [19:0] x_window;
    logic [19:0] y_window;
    logic [15:0] tx_window;
    logic [15:0] ty_window;
  } cfg_t;

  typedef struct packed {
    logic mark_second;
    logic mark_first;
    logic are_clones;
  } verdict_t;

endpackage

`default_nettype wire

### src/track_pair_clone_judge_top.sv
// Track pair clone judge: stream ports, held first track, config registers.
// Instantiates tpcj_judge; depends on tpcj_pkg.
`default_nettype none

// Takes one beat per cycle unless a stalled result holds the pair register. A
// beat with tuser low stores a track and gives no result; a beat with tuser high
// is judged against the stored track and its verdict reaches the master side
// through the pair register and then the result register around the judge logic.
// Config writes complete in the cycle they are presented.
module track_pair_clone_judge_top
  import tpcj_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // tdata from bit 0: shared_hits[7:0], hit_count[7:0], track_kind[1:0], is_fitted,
  // chi2_per_dof[17:0], has_beam_state, pos_z[25:0], pos_x[20:0], pos_y[20:0],
  // slope_x[17:0], slope_y[17:0], zero pad
  input  wire logic [InDataW-1:0]  s_tdata,
  input  wire logic                s_tuser,  // second_of_pair
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // tdata from bit 0: are_clones, mark_first, mark_second, zero pad
  output logic [OutDataW-1:0]      m_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  cfg_t     cfg;
  track_t   held;
  track_t   in_track;
  pair_t    pair;
  logic     pair_valid;
  verdict_t verdict;
  logic     s_accept, out_take, pair_adv;

  assign in_track.hit_count = s_tdata[15:8];
  assign in_track.kind      = s_tdata[17:16];
  assign in_track.fitted    = s_tdata[18];
  assign in_track.chi2      = s_tdata[36:19];
  assign in_track.has_state = s_tdata[37];
  assign in_track.z         = s_tdata[63:38];
  assign in_track.x         = s_tdata[84:64];
  assign in_track.y         = s_tdata[105:85];
  assign in_track.tx        = s_tdata[123:106];
  assign in_track.ty        = s_tdata[141:124];

  assign cfg_ready = 1'b1;
  assign out_take  = !m_tvalid || m_tready;
  assign pair_adv  = pair_valid && out_take;
  assign s_tready  = !pair_valid || out_take;
  assign s_accept  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_fraction        <= 9'd179;
      cfg.match_fraction_loose  <= 9'd128;
      cfg.loose_pair_enable     <= 1'b0;
      cfg.closeness_gate_enable <= 1'b0;
      cfg.x_window              <= 20'd102400;
      cfg.y_window              <= 20'd102400;
      cfg.tx_window             <= 16'd1966;
      cfg.ty_window             <= 16'd1311;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegMatchFraction: cfg.match_fraction        <= cfg_data[8:0];
        RegMatchLoose:    cfg.match_fraction_loose  <= cfg_data[8:0];
        RegLooseEnable:   cfg.loose_pair_enable     <= cfg_data[0];
        RegGateEnable:    cfg.closeness_gate_enable <= cfg_data[0];
        RegXWindow:       cfg.x_window              <= cfg_data[19:0];
        RegYWindow:       cfg.y_window              <= cfg_data[19:0];
        RegTxWindow:      cfg.tx_window             <= cfg_data[15:0];
        RegTyWindow:      cfg.ty_window             <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (s_accept && !s_tuser) begin
      held <= in_track;
    end
  end

  // pair register snapshots the held track with the second beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (s_accept && s_tuser) begin
      pair_valid <= 1'b1;
    end else if (pair_adv) begin
      pair_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && s_tuser) begin
      pair.first       <= held;
      pair.second      <= in_track;
      pair.shared_hits <= s_tdata[7:0];
    end
  end

  tpcj_judge u_judge (
    .pair    (pair),
    .cfg     (cfg),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pair_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_adv) begin
      m_tdata <= {{(OutDataW-3){1'b0}}, verdict.mark_second, verdict.mark_first,
                  verdict.are_clones};
    end
  end

endmodule

`default_nettype wire

### src/tpcj_judge.sv
// Verdict logic for one track pair: closeness gate, fraction tests, loser choice.
// Combinational; depends on tpcj_pkg.
`default_nettype none

module tpcj_judge
  import tpcj_pkg::*;
(
  input  pair_t    pair,
  input  cfg_t     cfg,
  output verdict_t verdict
);

  track_t t1;
  track_t t2;
  assign t1 = pair.first;
  assign t2 = pair.second;

  logic signed [25:0] z1, z2;
  logic signed [18:0] dtx, dty, stx, sty;
  logic [18:0]        adtx, adty;
  logic signed [26:0] dz;
  logic signed [21:0] dx, dy;
  logic signed [45:0] px, py;
  logic signed [46:0] ex, ey;
  logic [46:0]        aex, aey;
  logic               tx_ok, ty_ok, x_ok, y_ok, gate_ok;
  logic [7:0]         nmin;
  logic [15:0]        shared_sc;
  logic [16:0]        thr, thr_loose;
  logic               loose_pair, clones;

  assign z1  = $signed(t1.z);
  assign z2  = $signed(t2.z);
  assign dtx = $signed({t1.tx[17], t1.tx}) - $signed({t2.tx[17], t2.tx});
  assign dty = $signed({t1.ty[17], t1.ty}) - $signed({t2.ty[17], t2.ty});
  assign stx = $signed({t1.tx[17], t1.tx}) + $signed({t2.tx[17], t2.tx});
  assign sty = $signed({t1.ty[17], t1.ty}) + $signed({t2.ty[17], t2.ty});
  assign adtx = dtx[18] ? 19'(-dtx) : 19'(dtx);
  assign adty = dty[18] ? 19'(-dty) : 19'(dty);
  assign dz  = $signed({z1[25], z1}) - $signed({z2[25], z2});
  assign dx  = $signed({t1.x[20], t1.x}) - $signed({t2.x[20], t2.x});
  assign dy  = $signed({t1.y[20], t1.y}) - $signed({t2.y[20], t2.y});

  // position difference at midpoint z, scaled by 2^17
  assign px = 46'(stx) * 46'(dz);
  assign py = 46'(sty) * 46'(dz);
  assign ex = $signed({{8{dx[21]}}, dx, 17'b0}) - $signed({px[45], px});
  assign ey = $signed({{8{dy[21]}}, dy, 17'b0}) - $signed({py[45], py});
  assign aex = ex[46] ? 47'(-ex) : 47'(ex);
  assign aey = ey[46] ? 47'(-ey) : 47'(ey);

  assign tx_ok = adtx <= {3'b0, cfg.tx_window};
  assign ty_ok = adty <= {3'b0, cfg.ty_window};
  assign x_ok  = aex <= {10'b0, cfg.x_window, 17'b0};
  assign y_ok  = aey <= {10'b0, cfg.y_window, 17'b0};

  assign gate_ok = !cfg.closeness_gate_enable || !t1.has_state || !t2.has_state ||
                   (z1 > ZLimit) || (z2 > ZLimit) || (tx_ok && ty_ok && x_ok && y_ok);

  assign nmin      = (t1.hit_count < t2.hit_count) ? t1.hit_count : t2.hit_count;
  assign shared_sc = {pair.shared_hits, 8'b0};
  assign thr       = {8'b0, cfg.match_fraction} * {9'b0, nmin};
  assign thr_loose = {8'b0, cfg.match_fraction_loose} * {9'b0, nmin};
  assign loose_pair = cfg.loose_pair_enable && (t1.kind == KindLong) &&
                      ((t2.kind == KindDownstream) || (t2.kind == KindT));

  assign clones = gate_ok && (({1'b0, shared_sc} > thr) ||
                              (loose_pair && ({1'b0, shared_sc} > thr_loose)));

  always_comb begin
    verdict = '0;
    verdict.are_clones = clones;
    if (clones) begin
      if (t1.hit_count > t2.hit_count) begin
        verdict.mark_second = 1'b1;
      end else if (t2.hit_count > t1.hit_count) begin
        verdict.mark_first = 1'b1;
      end else if (t1.fitted && t2.fitted) begin
        if (t1.chi2 < t2.chi2) begin
          verdict.mark_second = 1'b1;
        end else begin
          verdict.mark_first = 1'b1;
        end
      end else begin
        verdict.mark_second = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/tpcj_checker.sv
// Port-level checks for the track pair clone judge, bound to the top level.
// Depends on tpcj_pkg.
`default_nettype none

module tpcj_checker
  import tpcj_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tuser,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic [OutDataW-1:0] m_tdata,
  input wire logic                m_tvalid,
  input wire logic                m_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_no_mark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> !m_tdata[1] && !m_tdata[2])
    else $error("loser marked without clone verdict");

  a_one_loser: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[1] != m_tdata[2]))
    else $error("clone verdict without exactly one loser");

  a_first_silent: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && s_tvalid && s_tready && !s_tuser && !$past(s_tvalid && s_tready && s_tuser)
    |=> !m_tvalid)
    else $error("stored track produced a result");

endmodule

bind track_pair_clone_judge_top tpcj_checker u_tpcj_checker (.*);

`default_nettype wire
